### rtl/core/sfc_pkg.sv
// Package for the snapshot file checker: beat and result types, codes,
// header layout constants and the byte-wide CRC-32 update function.
// Depends on nothing; every other file in rtl/core but sfc_if imports it.
package sfc_pkg;

  // Header layout (byte offsets from the start of the file)
  localparam int unsigned CountW = 34;
  localparam logic [CountW-1:0] HEADER_LEN  = 34'd29;
  localparam logic [CountW-1:0] VER_POS     = 34'd4;
  localparam logic [CountW-1:0] TERM_START  = 34'd13;
  localparam logic [CountW-1:0] PLEN_START  = 34'd21;
  localparam logic [CountW-1:0] PCRC_START  = 34'd25;
  localparam logic [CountW-1:0] CFG_HDR_LEN = 34'd8;
  localparam logic [CountW-1:0] CFG_LEN_LEN = 34'd4;
  localparam logic [CountW-1:0] COUNT_MAX   = {CountW{1'b1}};

  localparam logic [7:0] VERSION_1 = 8'h01;
  localparam logic [7:0] VERSION_2 = 8'h02;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

  // Magic "RKS1", one byte per header position 0..3
  localparam logic [7:0] MAGIC [4] = '{8'h52, 8'h4B, 8'h53, 8'h31};

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_CFG_HDR = 3'd2,
    KIND_CFG_DAT = 3'd3,
    KIND_EXCESS  = 3'd4
  } sfc_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MAGIC    = 3'd2,
    ST_VERSION  = 3'd3,
    ST_LENGTH   = 3'd4,
    ST_CFG_CRC  = 3'd5,
    ST_PAY_CRC  = 3'd6
  } sfc_status_t;

  // One input beat as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } sfc_beat_t;

  // One result beat as held in the result register
  typedef struct packed {
    logic [7:0]  out_byte;
    sfc_kind_t   byte_kind;
    logic        done_res;
    sfc_status_t status;
    logic [63:0] snapshot_index;
    logic [63:0] snapshot_term;
    logic [31:0] payload_length;
    logic [31:0] config_length;
  } sfc_res_t;

  // Reflected CRC-32 update over one byte, eight shift steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/core/sfc_if.sv
// Valid/ready channel interfaces for the snapshot file checker.
// Depends on nothing but the widths of the work fields.
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface sfc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [2:0]  byte_kind;
  logic        done_res;
  logic [2:0]  status;
  logic [63:0] snapshot_index;
  logic [63:0] snapshot_term;
  logic [31:0] payload_length;
  logic [31:0] config_length;

  modport source (output valid, output out_byte, output byte_kind, output done_res,
                  output status, output snapshot_index, output snapshot_term,
                  output payload_length, output config_length, input ready);
  modport sink   (input valid, input out_byte, input byte_kind, input done_res,
                  input status, input snapshot_index, input snapshot_term,
                  input payload_length, input config_length, output ready);
endinterface

### rtl/core/snapshot_file_checker.sv
// Path: a byte accepted into the input register moves on into the result
// register when the core takes it, and its result beat is offered from there.
// Throughput: one byte per cycle while the output channel is ready; the input
// register and the result register let a new byte enter while a finished result waits downstream.
// Reset: synchronous active-low rst_n empties both registers and sets the
// file state to its start-of-file values; the last byte of a file resets the file state too.
// Depends on sfc_pkg, sfc_if, sfc_in_stage and sfc_core.
module snapshot_file_checker (
  input  logic      clk,
  input  logic      rst_n,
  sfc_in_if.sink    in_ch,
  sfc_out_if.source out_ch
);
  import sfc_pkg::*;

  logic      take;
  logic      beat_vld;
  sfc_beat_t beat;

  // Input register
  sfc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .beat_vld (beat_vld),
    .beat     (beat)
  );

  // File state, verdict and result register
  sfc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .beat_vld (beat_vld),
    .beat     (beat),
    .take     (take),
    .out_ch   (out_ch)
  );

endmodule

### rtl/core/sfc_in_stage.sv
// Input register of the snapshot file checker: captures one beat from the
// input channel. Depends on sfc_pkg and sfc_in_if.
module sfc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  sfc_in_if.sink            in_ch,
  input  logic              take,
  output logic              beat_vld,
  output sfc_pkg::sfc_beat_t beat
);
  import sfc_pkg::*;

  logic      vld_r, vld_nxt;
  sfc_beat_t beat_r;

  // The register frees up when the core takes its beat in the same cycle.
  assign in_ch.ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.ready) begin
      vld_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      beat_r <= '{data_byte: in_ch.data_byte, last: in_ch.last};
    end
  end

  assign beat_vld = vld_r;
  assign beat     = beat_r;

endmodule

### rtl/core/sfc_core.sv
// File state, byte classification, CRC update and verdict, with the result
// register that drives the output channel. Depends on sfc_pkg, sfc_out_if.
module sfc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_vld,
  input  sfc_pkg::sfc_beat_t beat,
  output logic               take,
  sfc_out_if.source          out_ch
);
  import sfc_pkg::*;

  // File state
  logic [CountW-1:0] count_r, count_nxt;
  logic              magic_r, magic_nxt;
  logic [7:0]        ver_r, ver_nxt;
  logic [63:0]       idx_r, idx_nxt;
  logic [63:0]       term_r, term_nxt;
  logic [31:0]       plen_r, plen_nxt;
  logic [31:0]       pcrc_exp_r, pcrc_exp_nxt;
  logic [31:0]       clen_r, clen_nxt;
  logic [31:0]       ccrc_exp_r, ccrc_exp_nxt;
  logic [31:0]       pcrc_run_r, pcrc_run_nxt;
  logic [31:0]       ccrc_run_r, ccrc_run_nxt;

  // Result register
  logic     out_vld_r, out_vld_nxt;
  sfc_res_t res_r, res_nxt;

  // Section bounds, before and after this byte
  logic [CountW-1:0] pend, cfg_hdr_end, cfg_end;
  logic [CountW-1:0] pend_n, cfg_hdr_end_n, cfg_end_n;
  logic              v2, v2_n;
  sfc_kind_t         kind;
  sfc_status_t       st;

  // A beat moves on when the result register is empty or being drained.
  assign take = beat_vld && (!out_vld_r || out_ch.ready);

  // Classify the byte and update the file state.
  always_comb begin
    count_nxt    = count_r;
    magic_nxt    = magic_r;
    ver_nxt      = ver_r;
    idx_nxt      = idx_r;
    term_nxt     = term_r;
    plen_nxt     = plen_r;
    pcrc_exp_nxt = pcrc_exp_r;
    clen_nxt     = clen_r;
    ccrc_exp_nxt = ccrc_exp_r;
    pcrc_run_nxt = pcrc_run_r;
    ccrc_run_nxt = ccrc_run_r;

    pend        = HEADER_LEN + {2'b00, plen_r};
    cfg_hdr_end = pend + CFG_HDR_LEN;
    cfg_end     = cfg_hdr_end + {2'b00, clen_r};
    v2          = (ver_r == VERSION_2);
    kind        = KIND_EXCESS;

    if (count_r < HEADER_LEN) begin
      kind = KIND_HEADER;
      if (count_r < VER_POS) begin
        if (beat.data_byte != MAGIC[count_r[1:0]]) begin
          magic_nxt = 1'b0;
        end
      end else if (count_r == VER_POS) begin
        ver_nxt = beat.data_byte;
      end else if (count_r < TERM_START) begin
        idx_nxt = {idx_r[55:0], beat.data_byte};
      end else if (count_r < PLEN_START) begin
        term_nxt = {term_r[55:0], beat.data_byte};
      end else if (count_r < PCRC_START) begin
        plen_nxt = {plen_r[23:0], beat.data_byte};
      end else begin
        pcrc_exp_nxt = {pcrc_exp_r[23:0], beat.data_byte};
      end
    end else if (count_r < pend) begin
      kind         = KIND_PAYLOAD;
      pcrc_run_nxt = crc_byte(pcrc_run_r, beat.data_byte);
    end else if (v2 && (count_r < cfg_hdr_end)) begin
      kind = KIND_CFG_HDR;
      if (count_r < pend + CFG_LEN_LEN) begin
        clen_nxt = {clen_r[23:0], beat.data_byte};
      end else begin
        ccrc_exp_nxt = {ccrc_exp_r[23:0], beat.data_byte};
      end
    end else if (v2 && (count_r < cfg_end)) begin
      kind         = KIND_CFG_DAT;
      ccrc_run_nxt = crc_byte(ccrc_run_r, beat.data_byte);
    end

    // The byte counter saturates instead of wrapping.
    if (count_r != COUNT_MAX) begin
      count_nxt = count_r + 34'd1;
    end

    // Verdict in check order, from the state as it stands after this byte.
    pend_n        = HEADER_LEN + {2'b00, plen_nxt};
    cfg_hdr_end_n = pend_n + CFG_HDR_LEN;
    cfg_end_n     = cfg_hdr_end_n + {2'b00, clen_nxt};
    v2_n          = (ver_nxt == VERSION_2);
    if (count_nxt < HEADER_LEN) begin
      st = ST_SHORT;
    end else if (!magic_nxt) begin
      st = ST_MAGIC;
    end else if ((ver_nxt != VERSION_1) && !v2_n) begin
      st = ST_VERSION;
    end else if (!v2_n && (count_nxt != pend_n)) begin
      st = ST_LENGTH;
    end else if (v2_n && ((count_nxt < cfg_hdr_end_n) || (count_nxt != cfg_end_n))) begin
      st = ST_LENGTH;
    end else if (v2_n && ((ccrc_run_nxt ^ CRC_ONES) != ccrc_exp_nxt)) begin
      st = ST_CFG_CRC;
    end else if ((pcrc_run_nxt ^ CRC_ONES) != pcrc_exp_nxt) begin
      st = ST_PAY_CRC;
    end else begin
      st = ST_OK;
    end

    res_nxt = '{out_byte:       beat.data_byte,
                byte_kind:      kind,
                done_res:       beat.last,
                status:         ST_OK,
                snapshot_index: 64'd0,
                snapshot_term:  64'd0,
                payload_length: 32'd0,
                config_length:  32'd0};

    // The last byte reports the verdict and returns the state to reset.
    if (beat.last) begin
      res_nxt.status         = st;
      res_nxt.snapshot_index = idx_nxt;
      res_nxt.snapshot_term  = term_nxt;
      res_nxt.payload_length = plen_nxt;
      res_nxt.config_length  = v2_n ? clen_nxt : 32'd0;
      count_nxt    = '0;
      magic_nxt    = 1'b1;
      ver_nxt      = 8'd0;
      idx_nxt      = 64'd0;
      term_nxt     = 64'd0;
      plen_nxt     = 32'd0;
      pcrc_exp_nxt = 32'd0;
      clen_nxt     = 32'd0;
      ccrc_exp_nxt = 32'd0;
      pcrc_run_nxt = CRC_ONES;
      ccrc_run_nxt = CRC_ONES;
    end
  end

  // File state registers, updated once per taken beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      magic_r    <= 1'b1;
      ver_r      <= 8'd0;
      idx_r      <= 64'd0;
      term_r     <= 64'd0;
      plen_r     <= 32'd0;
      pcrc_exp_r <= 32'd0;
      clen_r     <= 32'd0;
      ccrc_exp_r <= 32'd0;
      pcrc_run_r <= CRC_ONES;
      ccrc_run_r <= CRC_ONES;
    end else if (take) begin
      count_r    <= count_nxt;
      magic_r    <= magic_nxt;
      ver_r      <= ver_nxt;
      idx_r      <= idx_nxt;
      term_r     <= term_nxt;
      plen_r     <= plen_nxt;
      pcrc_exp_r <= pcrc_exp_nxt;
      clen_r     <= clen_nxt;
      ccrc_exp_r <= ccrc_exp_nxt;
      pcrc_run_r <= pcrc_run_nxt;
      ccrc_run_r <= ccrc_run_nxt;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.out_byte       = res_r.out_byte;
  assign out_ch.byte_kind      = res_r.byte_kind;
  assign out_ch.done_res       = res_r.done_res;
  assign out_ch.status         = res_r.status;
  assign out_ch.snapshot_index = res_r.snapshot_index;
  assign out_ch.snapshot_term  = res_r.snapshot_term;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.config_length  = res_r.config_length;

  // A last beat leaves the counter at zero for the next file.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && beat.last |=> count_r == '0)
    else $error("byte counter not cleared after last byte");

  // Only a done result carries a verdict.
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.done_res |-> res_r.status == ST_OK)
    else $error("status set on a result that is not done");

  // Bytes below the header length are always tagged as header.
  a_header_kind: assert property (@(posedge clk) disable iff (!rst_n)
    take && (count_r < HEADER_LEN) |=> res_r.byte_kind == KIND_HEADER)
    else $error("header byte tagged with another role");

  // Config roles only appear in a version 2 file.
  a_cfg_needs_v2: assert property (@(posedge clk) disable iff (!rst_n)
    take && (ver_r != VERSION_2) |=>
      (res_r.byte_kind != KIND_CFG_HDR) && (res_r.byte_kind != KIND_CFG_DAT))
    else $error("config role outside a version 2 file");

endmodule
